FILE: design/smooth_cutoff_weight_eval_macros.svh
// assertion macros for the smooth cutoff weight evaluator
// used by the top level only; expects i_clk and i_rst_n in the including scope
`ifndef SMOOTH_CUTOFF_WEIGHT_EVAL_MACROS_SVH
`define SMOOTH_CUTOFF_WEIGHT_EVAL_MACROS_SVH

// same-cycle implication, checked outside reset
`define SCWE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SCWE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/scwe_pkg.sv
// shared types, constants and a saturation helper for the smooth cutoff weight evaluator
// no dependencies
`default_nettype none

package scwe_pkg;

    // fraction bits of the distance format (unsigned Q8.24)
    localparam int DIST_FRAC_BITS = 24;

    // one horner step per lower coefficient, each step a fixed-depth pipeline
    localparam int NUM_STEPS   = 5;
    localparam int STEP_STAGES = 5;
    localparam int SIDE_DEPTH  = NUM_STEPS * STEP_STAGES + 1;
    // input register, range check, horner steps, output register
    localparam int PIPE_LAT    = 3 + NUM_STEPS * STEP_STAGES;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C3    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_C4    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_C5    = 3'd7;

    typedef logic signed [63:0] t_s64;
    typedef logic [31:0]        t_dist;

    localparam t_s64 S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_s64 S64_MIN = 64'sh8000_0000_0000_0000;

    // per-item side data carried next to the horner lanes
    typedef struct packed {
        logic  flat;
        logic  cut;
        t_dist r_eff;
        t_dist r;
    } t_side;

    // k * c saturated to 64 bits, k a small constant
    function automatic t_s64 sat_scale(input t_s64 c, input logic [4:0] k);
        logic signed [69:0] ce;
        logic signed [69:0] ke;
        logic signed [69:0] p;
        ce = {{6{c[63]}}, c};
        ke = {65'd0, k};
        p  = ce * ke;
        if (p[69:63] == {7{p[69]}}) begin
            return p[63:0];
        end else if (p[69]) begin
            return S64_MIN;
        end else begin
            return S64_MAX;
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/smooth_cutoff_weight_eval.sv
// top level of the smooth cutoff weight evaluator: config registers, range check,
// up to three horner lanes per step and output select; uses scwe_pkg, scwe_mac_lane
// and smooth_cutoff_weight_eval_macros.svh
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | start, busy            | i_distance
//  result   | o_valid (one cycle)    | o_weight, o_slope, o_curvature
//  config   | i_cfg_we, i_cfg_idx    | i_cfg_data
//
// one item per cycle; each item passes the input register, the range check register,
// five horner steps of five stages each (magnitude, 32x32 multiply, 96-bit sum,
// saturate, coefficient add) and the output register before its result leaves.
// busy stays low: the pipeline never stops and the receiver takes every result.
// reset clears valid bits and config registers.
`default_nettype none

`include "smooth_cutoff_weight_eval_macros.svh"

module smooth_cutoff_weight_eval (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire scwe_pkg::t_dist               i_distance,
    output      logic                          o_valid,
    output scwe_pkg::t_s64                     o_weight,
    output scwe_pkg::t_s64                     o_slope,
    output scwe_pkg::t_s64                     o_curvature,
    input  wire logic                          i_cfg_we,
    input  wire logic [scwe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [63:0]                   i_cfg_data
);
    import scwe_pkg::*;

    localparam int LAST = SIDE_DEPTH - 1;

    // configuration
    t_dist r_inner;
    t_dist r_outer;
    t_s64  r_coef [0:5];

    // scaled coefficients for the derivative polynomials
    t_s64  r_d1 [0:4];
    t_s64  r_d2 [0:3];

    // input register
    logic  r_vld_in;
    t_dist r_dist;

    // side data line, one entry per pipeline stage
    logic  r_vld  [0:LAST];
    t_side r_side [0:LAST];
    t_side n_side;

    // lane accumulators at step boundaries
    t_s64  w_acc [0:NUM_STEPS];
    t_s64  s_acc [1:NUM_STEPS];
    t_s64  c_acc [2:NUM_STEPS];

    t_s64  n_weight;
    t_s64  n_slope;
    t_s64  n_curv;

    assign busy = 1'b0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= '0;
            r_outer <= '0;
            for (int i = 0; i < 6; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INNER: r_inner   <= i_cfg_data[31:0];
                REG_OUTER: r_outer   <= i_cfg_data[31:0];
                REG_C0:    r_coef[0] <= i_cfg_data;
                REG_C1:    r_coef[1] <= i_cfg_data;
                REG_C2:    r_coef[2] <= i_cfg_data;
                REG_C3:    r_coef[3] <= i_cfg_data;
                REG_C4:    r_coef[4] <= i_cfg_data;
                REG_C5:    r_coef[5] <= i_cfg_data;
                default:   r_inner   <= r_inner;
            endcase
        end
    end

    // derivative coefficients, refreshed every cycle from the config registers
    always_ff @(posedge i_clk) begin
        r_d1[0] <= r_coef[1];
        r_d1[1] <= sat_scale(r_coef[2], 5'd2);
        r_d1[2] <= sat_scale(r_coef[3], 5'd3);
        r_d1[3] <= sat_scale(r_coef[4], 5'd4);
        r_d1[4] <= sat_scale(r_coef[5], 5'd5);
        r_d2[0] <= sat_scale(r_coef[2], 5'd2);
        r_d2[1] <= sat_scale(r_coef[3], 5'd6);
        r_d2[2] <= sat_scale(r_coef[4], 5'd12);
        r_d2[3] <= sat_scale(r_coef[5], 5'd20);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_in <= 1'b0;
            for (int i = 0; i <= LAST; i++) begin
                r_vld[i] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else begin
            r_vld_in <= start && !busy;
            r_vld[0] <= r_vld_in;
            for (int i = 1; i <= LAST; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            o_valid <= r_vld[LAST];
        end
    end

    // range check: flat region evaluates the weight at the inner radius
    always_comb begin
        n_side.r     = r_dist;
        n_side.flat  = r_dist < r_inner;
        n_side.cut   = !n_side.flat && (r_dist > r_outer);
        n_side.r_eff = n_side.flat ? r_inner : r_dist;
    end

    // item payload and side line
    always_ff @(posedge i_clk) begin
        r_dist    <= i_distance;
        r_side[0] <= n_side;
        for (int i = 1; i <= LAST; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // top coefficients seed each lane where it starts
    assign w_acc[0] = r_coef[5];
    assign s_acc[1] = r_d1[4];
    assign c_acc[2] = r_d2[3];

    // horner steps; slope joins at step one, curvature at step two
    for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
        scwe_mac_lane u_w (
            .i_clk  (i_clk),
            .i_acc  (w_acc[j]),
            .i_r    (r_side[j*STEP_STAGES].r_eff),
            .i_coef (r_coef[NUM_STEPS-1-j]),
            .o_acc  (w_acc[j+1])
        );
        if (j >= 1) begin : g_slope
            scwe_mac_lane u_s (
                .i_clk  (i_clk),
                .i_acc  (s_acc[j]),
                .i_r    (r_side[j*STEP_STAGES].r),
                .i_coef (r_d1[NUM_STEPS-1-j]),
                .o_acc  (s_acc[j+1])
            );
        end
        if (j >= 2) begin : g_curv
            scwe_mac_lane u_c (
                .i_clk  (i_clk),
                .i_acc  (c_acc[j]),
                .i_r    (r_side[j*STEP_STAGES].r),
                .i_coef (r_d2[NUM_STEPS-1-j]),
                .o_acc  (c_acc[j+1])
            );
        end
    end

    // output select by region
    always_comb begin
        n_weight = w_acc[NUM_STEPS];
        n_slope  = s_acc[NUM_STEPS];
        n_curv   = c_acc[NUM_STEPS];
        if (r_side[LAST].flat) begin
            n_slope = '0;
            n_curv  = '0;
        end else if (r_side[LAST].cut) begin
            n_weight = '0;
            n_slope  = '0;
            n_curv   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        o_weight    <= n_weight;
        o_slope     <= n_slope;
        o_curvature <= n_curv;
    end

    // checks
    `SCWE_ASSERT_IMPLIES(a_out_has_item, o_valid, $past(start && !busy, PIPE_LAT), "result without item")
    `SCWE_ASSERT_IMPLIES(a_item_gives_out, start && !busy, ##PIPE_LAT o_valid, "item without result")
    `SCWE_ASSERT_NEXT(a_cut_zero, r_vld[LAST] && r_side[LAST].cut, o_weight == 0 && o_slope == 0 && o_curvature == 0, "cutoff result not zero")
    `SCWE_ASSERT_NEXT(a_flat_zero, r_vld[LAST] && r_side[LAST].flat, o_slope == 0 && o_curvature == 0, "flat derivatives not zero")

endmodule

`default_nettype wire

FILE: design/scwe_mac_lane.sv
// one horner step: round(acc * r / 2^F) saturated, plus coefficient, saturated
// five register stages; uses scwe_pkg
`default_nettype none

module scwe_mac_lane (
    input  wire logic          i_clk,
    input  wire scwe_pkg::t_s64  i_acc,
    input  wire scwe_pkg::t_dist i_r,
    input  wire scwe_pkg::t_s64  i_coef,
    output scwe_pkg::t_s64     o_acc
);
    import scwe_pkg::*;

    localparam logic [95:0] ROUND_HALF = 96'd1 << (DIST_FRAC_BITS - 1);

    logic [63:0] r_mag;
    logic        r_neg_a;
    t_dist       r_r;
    logic [63:0] r_pp_lo;
    logic [63:0] r_pp_hi;
    logic        r_neg_b;
    logic [95:0] r_sum;
    logic        r_neg_c;
    t_s64        r_prod;
    t_s64        r_acc;

    logic [63:0] acc_u;
    logic [63:0] n_mag;
    logic        ovf;
    logic [63:0] mag_q;
    t_s64        n_prod;
    logic [64:0] sum65;
    t_s64        n_acc;

    // stage a: sign and magnitude
    assign acc_u = i_acc;
    assign n_mag = i_acc[63] ? (64'd0 - acc_u) : acc_u;

    // stage d: drop fraction, saturate, restore sign
    assign ovf   = |r_sum[95:DIST_FRAC_BITS+64];
    assign mag_q = r_sum[DIST_FRAC_BITS+63:DIST_FRAC_BITS];
    always_comb begin
        if (r_neg_c) begin
            n_prod = (ovf || mag_q[63]) ? S64_MIN : -$signed(mag_q);
        end else begin
            n_prod = (ovf || mag_q[63]) ? S64_MAX : $signed(mag_q);
        end
    end

    // stage e: saturating add of the next coefficient
    assign sum65 = {r_prod[63], r_prod} + {i_coef[63], i_coef};
    always_comb begin
        if (sum65[64] != sum65[63]) begin
            n_acc = sum65[64] ? S64_MIN : S64_MAX;
        end else begin
            n_acc = sum65[63:0];
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg_a <= i_acc[63];
        r_r     <= i_r;
        // two 32x32 partial products
        r_pp_lo <= r_mag[31:0] * r_r;
        r_pp_hi <= r_mag[63:32] * r_r;
        r_neg_b <= r_neg_a;
        // full product plus half lsb for round half away from zero
        r_sum   <= {32'd0, r_pp_lo} + {r_pp_hi, 32'd0} + ROUND_HALF;
        r_neg_c <= r_neg_b;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

FILE: bench/tb_smooth_cutoff_weight_eval.sv
// self-checking bench for smooth_cutoff_weight_eval: queued stimulus, negedge driver,
// posedge monitor with a bit-exact quintic weight predictor
// depends on scwe_pkg and the smooth_cutoff_weight_eval top level
`timescale 1ns / 1ps

module tb_smooth_cutoff_weight_eval;
    import scwe_pkg::*;

    typedef logic [5:0][63:0] t_coef_set;

    typedef struct packed {
        t_s64 weight;
        t_s64 slope;
        t_s64 curvature;
    } t_weight_triple;

    typedef enum logic [1:0] {
        STIM_ITEM,
        STIM_FENCE,
        STIM_CFG
    } t_stim_kind;

    typedef struct packed {
        t_stim_kind             kind;
        logic [4:0]             gap;
        logic [CFG_IDX_W-1:0]   idx;
        logic [63:0]            data;
    } t_stim;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    t_dist                  i_distance = '0;
    logic                   o_valid;
    t_s64                   o_weight;
    t_s64                   o_slope;
    t_s64                   o_curvature;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = REG_INNER;
    logic [63:0]            i_cfg_data = '0;

    t_stim          stim_q[$];
    t_weight_triple results_due[$];
    int unsigned    errors = 0;
    logic           item_taken = 1'b0;
    int unsigned    idle_left = 0;

    // predictor copy of the configuration
    t_dist     m_inner = '0;
    t_dist     m_outer = '0;
    t_coef_set m_coef = '0;

    // stimulus-side view of the current radii and idle style
    t_dist       gen_inner;
    t_dist       gen_outer;
    int unsigned idle_mode = 0;

    smooth_cutoff_weight_eval u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_distance  (i_distance),
        .o_valid     (o_valid),
        .o_weight    (o_weight),
        .o_slope     (o_slope),
        .o_curvature (o_curvature),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // fixed-point helpers of the predictor
    function automatic t_s64 sat64(input logic signed [71:0] v);
        if (v[71:63] == {9{v[71]}}) begin
            return v[63:0];
        end
        return v[71] ? S64_MIN : S64_MAX;
    endfunction

    function automatic t_s64 scale_coef(input t_s64 c, input int k);
        return sat64(72'(c) * 72'(k));
    endfunction

    // round(a * r / 2^DIST_FRAC_BITS), ties away from zero
    function automatic t_s64 mul_distance(input t_s64 a, input t_dist r);
        logic [63:0] mag;
        logic [96:0] prod;
        logic [96:0] m;
        mag  = a[63] ? 64'(-a) : 64'(a);
        prod = 97'(mag) * 97'(r) + (97'd1 << (DIST_FRAC_BITS - 1));
        m    = prod >> DIST_FRAC_BITS;
        if (a[63]) begin
            if (m >= 97'h8000_0000_0000_0000) begin
                return S64_MIN;
            end
            return t_s64'(~m[63:0] + 64'd1);
        end
        if (m > 97'h7FFF_FFFF_FFFF_FFFF) begin
            return S64_MAX;
        end
        return t_s64'(m[63:0]);
    endfunction

    // horner evaluation from coefficient index top down to 0
    function automatic t_s64 eval_poly(input t_coef_set c, input int top, input t_dist r);
        t_s64 acc;
        acc = c[top];
        for (int k = top - 1; k >= 0; k--) begin
            acc = sat64(72'(mul_distance(acc, r)) + 72'(t_s64'(c[k])));
        end
        return acc;
    endfunction

    function automatic t_weight_triple predict_triple(input t_dist r);
        t_coef_set      slope_c;
        t_coef_set      curv_c;
        t_weight_triple res;
        res     = '0;
        slope_c = '0;
        curv_c  = '0;
        if (r < m_inner) begin
            res.weight = eval_poly(m_coef, 5, m_inner);
        end else if (r <= m_outer) begin
            slope_c[0] = m_coef[1];
            slope_c[1] = scale_coef(m_coef[2], 2);
            slope_c[2] = scale_coef(m_coef[3], 3);
            slope_c[3] = scale_coef(m_coef[4], 4);
            slope_c[4] = scale_coef(m_coef[5], 5);
            curv_c[0]  = scale_coef(m_coef[2], 2);
            curv_c[1]  = scale_coef(m_coef[3], 6);
            curv_c[2]  = scale_coef(m_coef[4], 12);
            curv_c[3]  = scale_coef(m_coef[5], 20);
            res.weight    = eval_poly(m_coef, 5, r);
            res.slope     = eval_poly(slope_c, 4, r);
            res.curvature = eval_poly(curv_c, 3, r);
        end
        return res;
    endfunction

    task automatic check_field(input string what, input t_s64 want, input t_s64 got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    // driver: one item, register write or fence per step, launched at negedge
    always @(negedge i_clk) begin : drive
        logic                 nx_start;
        logic                 nx_we;
        t_dist                nx_dist;
        logic [CFG_IDX_W-1:0] nx_idx;
        logic [63:0]          nx_data;
        t_stim                head;
        nx_start = 1'b0;
        nx_we    = 1'b0;
        nx_dist  = i_distance;
        nx_idx   = i_cfg_idx;
        nx_data  = i_cfg_data;
        if (start && !item_taken) begin
            nx_start = 1'b1;
        end else if (i_rst_n && stim_q.size() != 0) begin
            head = stim_q[0];
            if (idle_left != 0) begin
                idle_left--;
            end else begin
                case (head.kind)
                    STIM_ITEM: begin
                        nx_start  = 1'b1;
                        nx_dist   = head.data[31:0];
                        idle_left = head.gap;
                        head      = stim_q.pop_front();
                    end
                    STIM_FENCE: begin
                        if (results_due.size() == 0) begin
                            head = stim_q.pop_front();
                        end
                    end
                    default: begin
                        nx_we   = 1'b1;
                        nx_idx  = head.idx;
                        nx_data = head.data;
                        head    = stim_q.pop_front();
                    end
                endcase
            end
        end
        start      <= nx_start;
        i_distance <= nx_dist;
        i_cfg_we   <= nx_we;
        i_cfg_idx  <= nx_idx;
        i_cfg_data <= nx_data;
    end

    // monitor: check results, track register writes, predict accepted items
    always @(posedge i_clk) begin : watch
        t_weight_triple want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result, actual %h %h %h", $time,
                             o_weight, o_slope, o_curvature);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("weight", want.weight, o_weight);
                    check_field("slope", want.slope, o_slope);
                    check_field("curvature", want.curvature, o_curvature);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INNER: m_inner = i_cfg_data[31:0];
                    REG_OUTER: m_outer = i_cfg_data[31:0];
                    REG_C0, REG_C1, REG_C2, REG_C3, REG_C4, REG_C5:
                        m_coef[i_cfg_idx - REG_C0] = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                results_due.push_back(predict_triple(i_distance));
            end
            item_taken <= start && !busy;
        end else begin
            item_taken <= 1'b0;
        end
    end

    // stimulus building blocks
    function automatic int unsigned next_gap();
        if ($urandom_range(0, 99) < 3) begin
            idle_mode = $urandom_range(0, 2);
        end
        case (idle_mode)
            0: return 0;
            1: return $urandom_range(0, 19);
            default: return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 0;
        endcase
    endfunction

    task automatic push_item(input t_dist r);
        t_stim s;
        s      = '0;
        s.kind = STIM_ITEM;
        s.gap  = 5'(next_gap());
        s.data = {32'd0, r};
        stim_q.push_back(s);
    endtask

    task automatic push_fence();
        t_stim s;
        s      = '0;
        s.kind = STIM_FENCE;
        stim_q.push_back(s);
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        t_stim s;
        s      = '0;
        s.kind = STIM_CFG;
        s.idx  = idx;
        s.data = data;
        stim_q.push_back(s);
    endtask

    // wait for an empty pipeline, then rewrite every register
    task automatic load_config(input t_dist inner, input t_dist outer, input t_coef_set c);
        push_fence();
        // upper data bits of the radius writes are don't-care
        push_cfg(REG_INNER, {$urandom(), inner});
        push_cfg(REG_OUTER, {$urandom(), outer});
        push_cfg(REG_C0, c[0]);
        push_cfg(REG_C1, c[1]);
        push_cfg(REG_C2, c[2]);
        push_cfg(REG_C3, c[3]);
        push_cfg(REG_C4, c[4]);
        push_cfg(REG_C5, c[5]);
        gen_inner = inner;
        gen_outer = outer;
    endtask

    function automatic t_s64 rand_coef();
        t_s64        raw;
        int unsigned sel;
        raw = {$urandom(), $urandom()};
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            return raw >>> $urandom_range(12, 22);
        end else if (sel < 90) begin
            return raw;
        end
        case ($urandom_range(0, 4))
            0: return S64_MAX;
            1: return S64_MIN;
            2: return '0;
            3: return -64'sd1;
            default: return 64'sd1;
        endcase
    endfunction

    function automatic t_dist clamp_dist(input longint v);
        if (v < 0) begin
            return '0;
        end
        if (v > 64'hFFFF_FFFF) begin
            return '1;
        end
        return t_dist'(v);
    endfunction

    // distances biased toward the configured window and its edges
    function automatic t_dist pick_distance();
        longint      hi_r;
        longint      edge_r;
        int unsigned sel;
        hi_r = (gen_outer > gen_inner) ? longint'(gen_outer) : longint'(gen_inner);
        sel  = $urandom_range(0, 99);
        if (sel < 55) begin
            return clamp_dist(longint'({$urandom(), $urandom()} % (hi_r + hi_r / 8 + 2)));
        end else if (sel < 75) begin
            edge_r = $urandom_range(0, 1) ? longint'(gen_inner) : longint'(gen_outer);
            return clamp_dist(edge_r + $urandom_range(0, 4) - 2);
        end else if (sel < 90) begin
            return $urandom();
        end
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return gen_inner;
            default: return gen_outer;
        endcase
    endfunction

    // reset and stimulus
    initial begin : stimulus
        t_coef_set   cs;
        int unsigned items_made;
        int unsigned phase_len;
        t_dist       ra;
        t_dist       rb;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // smooth falloff between 1.0 and 3.0
        cs[0] = 64'sh0000_0200_0000_0000;
        cs[1] = -64'sh0000_0080_0000_0000;
        cs[2] = 64'sh0000_0040_0000_0000;
        cs[3] = -64'sh0000_0010_0000_0000;
        cs[4] = 64'sh0000_0004_0000_0000;
        cs[5] = -64'sh0000_0000_8000_0000;
        load_config(32'h0100_0000, 32'h0300_0000, cs);
        push_item(32'h0000_0000);
        push_item(32'h00FF_FFFF);
        push_item(32'h0100_0000);
        push_item(32'h0100_0001);
        push_item(32'h0200_0000);
        push_item(32'h02FF_FFFF);
        push_item(32'h0300_0000);
        push_item(32'h0300_0001);
        push_item(32'hFFFF_FFFF);
        push_item(32'hAAAA_AAAA);

        // saturation of every lane over the full distance range
        cs = {S64_MIN, S64_MAX, S64_MIN, S64_MAX, S64_MIN, S64_MAX};
        load_config(32'h0000_0000, 32'hFFFF_FFFF, cs);
        push_item(32'h0000_0000);
        push_item(32'h0000_0001);
        push_item(32'h0080_0000);
        push_item(32'h0100_0000);
        push_item(32'hFFFF_FFFF);

        // swapped radii, tiny coefficients to hit rounding ties
        cs = '0;
        cs[5] = -64'sd1;
        cs[4] = 64'sd3;
        cs[1] = 64'sd1;
        load_config(32'h0200_0000, 32'h0100_0000, cs);
        push_item(32'h0000_0000);
        push_item(32'h0080_0000);
        push_item(32'h0180_0000);
        push_item(32'h01FF_FFFF);
        push_item(32'h0200_0000);

        // zero-width window
        cs = {6{S64_MIN}};
        load_config(32'h0000_0000, 32'h0000_0000, cs);
        push_item(32'h0000_0000);
        push_item(32'h0000_0001);

        // random phases, each with its own configuration
        items_made = 0;
        while (items_made < 1200) begin
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    rb = $urandom_range(0, 32'h0300_0000);
                    ra = rb + $urandom_range(1, 32'h0200_0000);
                end
                3, 4, 5: begin
                    ra = $urandom();
                    rb = $urandom();
                end
                6: begin
                    ra = $urandom_range(0, 1) ? 32'h0000_0000 : $urandom();
                    rb = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ra;
                end
                default: begin
                    ra = $urandom_range(0, 32'h0200_0000);
                    rb = ra + $urandom_range(0, 32'h0600_0000);
                end
            endcase
            for (int k = 0; k < 6; k++) begin
                cs[k] = rand_coef();
            end
            load_config(ra, rb, cs);
            phase_len = $urandom_range(40, 120);
            for (int n = 0; n < phase_len; n++) begin
                // occasional drain in the middle of a phase
                if ($urandom_range(0, 199) == 0) begin
                    push_fence();
                end
                push_item(pick_distance());
            end
            items_made += phase_len;
        end

        do begin
            @(posedge i_clk);
        end while (stim_q.size() != 0 || results_due.size() != 0 || start);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, results_due.size());
            errors++;
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
